// File: design/khsr_pkg.sv
package khsr_pkg;

  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_RANGE  = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  localparam logic [1:0] ROUTE_MASTER  = 2'd0;
  localparam logic [1:0] ROUTE_REPLICA = 2'd1;
  localparam logic [1:0] ROUTE_DOWN    = 2'd2;
  localparam logic [1:0] ROUTE_NONE    = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [5:0]  entry_index;
    logic        entry_valid;
    logic [13:0] range_low;
    logic [13:0] range_high;
    logic [3:0]  shard_sel;
    logic        master_up;
    logic        replica_up;
  } req_t;

  typedef struct packed {
    logic [15:0] key_crc;
    logic [13:0] hash_slot;
    logic [3:0]  shard_out;
    logic [1:0]  route;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [13:0] low;
    logic [13:0] high;
    logic [3:0]  shard;
  } range_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic take;
    logic mod_step;
    logic scan_init;
    logic scan_step;
    logic stat_read;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_key;
    logic clear_last;
    logic mod_last;
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

// File: design/khsr_ctrl.sv
module khsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  khsr_pkg::stat_t st,
  output khsr_pkg::cmd_t  cmd
);
  import khsr_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = req_valid;
        if (req_valid && st.final_key) state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_STAT;
      end
      S_STAT: begin
        cmd.stat_read = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // Hold the finished result until the output register can take it.
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !cmd.clear && !cmd.scan_step && !cmd.load_out)
    else $error("input accepted while the block is busy");

  a_final_starts_mod: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && st.final_key) |=> state == S_MOD)
    else $error("final key byte did not start the slot computation");

  a_scan_to_stat: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && st.scan_last) |=> cmd.stat_read)
    else $error("status lookup did not follow the range scan");

endmodule

// File: design/khsr_dp.sv
module khsr_dp #(
  parameter int SLOTS  = 16384,
  parameter int RANGES = 64,
  parameter int SHARDS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  khsr_pkg::cmd_t  cmd,
  output khsr_pkg::stat_t st,
  input  khsr_pkg::req_t  req,
  output khsr_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_ready
);
  import khsr_pkg::*;

  localparam int IW    = (RANGES > 1) ? $clog2(RANGES) : 1;
  localparam int AW    = $clog2(RANGES + 1);
  localparam int SW    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int RW    = $clog2(SLOTS) + 1;
  localparam int CLR_N = (RANGES > SHARDS) ? RANGES : SHARDS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  // Rounded-up 2^32 / SLOTS; exact for every 16-bit dividend and SLOTS up to 2^16.
  localparam logic [31:0] SLOT_RECIP =
    32'(((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [31:0] SLOT_DIV = 32'(SLOTS);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [15:0]  running_crc;
  logic [15:0]  key_crc;
  logic         mod_cnt;
  logic [47:0]  mod_prod;
  logic [15:0]  mod_quo;
  logic [31:0]  mod_back;
  logic [31:0]  mod_diff;
  logic [RW-1:0] rem;
  logic [CW-1:0] clr_cnt;
  logic [AW-1:0] scan_addr;
  logic          rd_pend;
  logic          rd_last;
  range_entry_t  rd_entry;
  logic          found;
  logic [3:0]    best;
  logic [1:0]    stat_rd;
  logic          stat_ok;
  logic [15:0]   crc_new;
  logic          is_key;
  logic          wr_range;
  logic          wr_stat;
  logic          issue;
  logic          hit;
  logic [1:0]    route;

  range_entry_t tbl [RANGES];
  logic [1:0]   smem [SHARDS];

  assign crc_new  = crc_feed(running_crc, req.key_byte);
  assign is_key   = (req.req_type == REQ_KEY);
  assign wr_range = cmd.take && (req.req_type == REQ_RANGE) && (32'(req.entry_index) < RANGES);
  assign wr_stat  = cmd.take && (req.req_type == REQ_STATUS) && (32'(req.shard_sel) < SHARDS);

  assign st.final_key  = is_key && req.key_last;
  assign st.clear_last = (clr_cnt == CW'(CLR_N - 1));
  assign st.mod_last   = (mod_cnt == 1'b1);
  assign st.scan_last  = rd_pend && rd_last;
  assign st.out_busy   = rsp_valid && !rsp_ready;

  // CRC register; it returns to zero once a key is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (cmd.take && is_key) begin
      running_crc <= req.key_last ? 16'h0000 : crc_new;
    end
  end

  // Remainder by the slot count through a reciprocal: the quotient is registered
  // first, then the remainder.
  assign mod_prod = 48'(key_crc) * 48'(SLOT_RECIP);
  assign mod_back = 32'(mod_quo) * SLOT_DIV;
  assign mod_diff = 32'(key_crc) - mod_back;

  always_ff @(posedge clk) begin
    if (cmd.take && st.final_key) begin
      key_crc <= crc_new;
      mod_cnt <= 1'b0;
    end else if (cmd.mod_step) begin
      if (!mod_cnt) begin
        mod_quo <= mod_prod[47:32];
      end else begin
        rem <= mod_diff[RW-1:0];
      end
      mod_cnt <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign issue = cmd.scan_step && (32'(scan_addr) < RANGES);

  always_ff @(posedge clk) begin
    if (cmd.clear && (32'(clr_cnt) < RANGES)) begin
      tbl[IW'(clr_cnt)] <= '0;
    end else if (wr_range) begin
      tbl[IW'(req.entry_index)] <= '{valid: req.entry_valid, low: req.range_low,
                                     high: req.range_high, shard: req.shard_sel};
    end
    if (cmd.scan_step) begin
      rd_entry <= tbl[scan_addr[IW-1:0]];
    end
  end

  assign hit = rd_pend && rd_entry.valid &&
               (32'(rd_entry.low) <= 32'(rem)) && (32'(rem) <= 32'(rd_entry.high)) &&
               (!found || (rd_entry.shard < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      found   <= 1'b0;
      best    <= '0;
    end else if (cmd.scan_init) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      best      <= '0;
    end else if (cmd.scan_step) begin
      if (issue) scan_addr <= scan_addr + 1'b1;
      rd_pend <= issue;
      rd_last <= (32'(scan_addr) == RANGES - 1);
      if (hit) begin
        found <= 1'b1;
        best  <= rd_entry.shard;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && (32'(clr_cnt) < SHARDS)) begin
      smem[SW'(clr_cnt)] <= '0;
    end else if (wr_stat) begin
      smem[SW'(req.shard_sel)] <= {req.replica_up, req.master_up};
    end
    if (cmd.stat_read) begin
      stat_rd <= smem[SW'(best)];
      stat_ok <= (32'(best) < SHARDS);
    end
  end

  always_comb begin
    if (!found) begin
      route = ROUTE_NONE;
    end else if (stat_ok && stat_rd[0]) begin
      route = ROUTE_MASTER;
    end else if (stat_ok && stat_rd[1]) begin
      route = ROUTE_REPLICA;
    end else begin
      route = ROUTE_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.key_crc   <= key_crc;
      rsp.hash_slot <= 14'(rem);
      rsp.shard_out <= found ? best : 4'd0;
      rsp.route     <= route;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("loaded result is not presented");

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && st.final_key) |=> running_crc == 16'h0000)
    else $error("CRC did not restart after the last key byte");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_init |=> 32'(rem) < SLOTS)
    else $error("slot remainder out of range");

  a_found_in_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> $past(cmd.scan_step))
    else $error("match flag set outside the range scan");

endmodule

// File: design/key_hash_slot_router.sv
// Key bytes that are not last are taken one per cycle while the block is idle, with no result.
// A last key byte starts the routing: the slot remainder, then a scan of the range table
// through its registered read port, one status read, then the result register; at most
// one key is in flight.
// A result still waiting for rsp_ready holds the next finished result back until it is taken.
// Reset clears the CRC, then the range table and status store are swept clear before input is taken.
module key_hash_slot_router #(
  parameter int SLOTS  = 16384,
  parameter int RANGES = 64,
  parameter int SHARDS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  khsr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output khsr_pkg::rsp_t rsp
);
  import khsr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  khsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  khsr_dp #(
    .SLOTS  (SLOTS),
    .RANGES (RANGES),
    .SHARDS (SHARDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

// File: dv/key_hash_slot_router_tb.sv
module key_hash_slot_router_tb;
  import khsr_pkg::*;

  localparam int SLOTS  = 16384;
  localparam int RANGES = 64;
  localparam int SHARDS = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int REQ_W = $bits(req_t);
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_AFTER   = 1200;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  bit calm = 1'b0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  key_hash_slot_router #(
    .SLOTS(SLOTS),
    .RANGES(RANGES),
    .SHARDS(SHARDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // Mirrors the CRC, the range table and the shard health flags, and keeps the
  // routes that accepted last key bytes still owe.
  class route_predictor;
    logic [15:0]  crc_acc;
    range_entry_t ranges[RANGES];
    logic [1:0]   health[SHARDS];
    rsp_t         routes_due[$];
    int           errors;

    function new();
      crc_acc = '0;
      foreach (ranges[i]) ranges[i] = '0;
      foreach (health[i]) health[i] = '0;
      errors = 0;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
      return x;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    function void note_request(req_t r);
      int   slot;
      int   best;
      bit   found;
      logic [1:0] st;
      rsp_t want;
      case (r.req_type)
        REQ_RANGE: begin
          if (int'(r.entry_index) < RANGES) begin
            ranges[r.entry_index].valid = r.entry_valid;
            ranges[r.entry_index].low   = r.range_low;
            ranges[r.entry_index].high  = r.range_high;
            ranges[r.entry_index].shard = r.shard_sel;
          end
        end
        REQ_STATUS: begin
          if (int'(r.shard_sel) < SHARDS) health[r.shard_sel] = {r.replica_up, r.master_up};
        end
        REQ_KEY: begin
          crc_acc = crc_byte(crc_acc, r.key_byte);
          if (r.key_last) begin
            slot  = int'(crc_acc) % SLOTS;
            found = 1'b0;
            best  = 0;
            foreach (ranges[i]) begin
              if (ranges[i].valid && int'(ranges[i].low) <= slot &&
                  slot <= int'(ranges[i].high) && (!found || int'(ranges[i].shard) < best)) begin
                best  = int'(ranges[i].shard);
                found = 1'b1;
              end
            end
            want.key_crc   = crc_acc;
            want.hash_slot = slot[13:0];
            if (!found) begin
              want.shard_out = '0;
              want.route     = ROUTE_NONE;
            end else begin
              st = (best < SHARDS) ? health[best] : 2'b00;
              want.shard_out = best[3:0];
              if (st[0]) want.route = ROUTE_MASTER;
              else if (st[1]) want.route = ROUTE_REPLICA;
              else want.route = ROUTE_DOWN;
            end
            routes_due.push_back(want);
            crc_acc = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) report($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    function void check_route(rsp_t got);
      rsp_t want;
      if (routes_due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = routes_due.pop_front();
        compare_field("key_crc", want.key_crc, got.key_crc);
        compare_field("hash_slot", 16'(want.hash_slot), 16'(got.hash_slot));
        compare_field("shard_out", 16'(want.shard_out), 16'(got.shard_out));
        compare_field("route", 16'(want.route), 16'(got.route));
      end
    endfunction
  endclass

  route_predictor sb = new();

  function automatic req_t filler();
    req_t r;
    r = REQ_W'({$urandom(), $urandom()});
    return r;
  endfunction

  function automatic req_t key_item(logic [7:0] b, logic last);
    req_t r;
    r = filler();
    r.req_type = REQ_KEY;
    r.key_byte = b;
    r.key_last = last;
    return r;
  endfunction

  function automatic req_t range_item(int idx, logic v, int lo, int hi, int shard);
    req_t r;
    r = filler();
    r.req_type    = REQ_RANGE;
    r.entry_index = idx[5:0];
    r.entry_valid = v;
    r.range_low   = lo[13:0];
    r.range_high  = hi[13:0];
    r.shard_sel   = shard[3:0];
    return r;
  endfunction

  function automatic req_t status_item(int shard, logic m, logic rep);
    req_t r;
    r = filler();
    r.req_type   = REQ_STATUS;
    r.shard_sel  = shard[3:0];
    r.master_up  = m;
    r.replica_up = rep;
    return r;
  endfunction

  // Optionally holds off for a short burst, then presents one transaction and
  // waits for it to be taken.
  task automatic send_request(input req_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic send_key(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_request(key_item(bytes[i], i == bytes.size() - 1));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_route(rsp);
  end

  // Result side: random stall bursts until the quiet tail of the run.
  initial begin
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int pick;
    int lo;
    int hi;
    int done;
    logic [7:0] check_str[$];
    req_t r;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Keys before any range exists find no shard.
    send_request(key_item(8'h00, 1'b1));
    send_request(key_item(8'hFF, 1'b1));
    // One range over every slot, owned by the top shard, which is still down.
    send_request(range_item(0, 1'b1, 0, SLOTS - 1, SHARDS - 1));
    send_request(key_item(8'h41, 1'b1));
    send_request(status_item(SHARDS - 1, 1'b0, 1'b1));
    send_request(key_item(8'h41, 1'b1));
    send_request(status_item(SHARDS - 1, 1'b1, 1'b1));
    send_request(key_item(8'h5A, 1'b1));
    // An inverted range and an inactive range must never match.
    send_request(range_item(1, 1'b1, SLOTS - 1, 0, 0));
    send_request(range_item(2, 1'b0, 0, SLOTS - 1, 1));
    send_request(key_item(8'h80, 1'b1));
    // A lower shard covering the same slots takes over.
    send_request(range_item(RANGES - 1, 1'b1, 0, SLOTS - 1, 2));
    send_request(status_item(2, 1'b0, 1'b0));
    send_request(key_item(8'h01, 1'b1));
    send_request(status_item(0, 1'b1, 1'b0));
    // The unused request type changes nothing.
    r = filler();
    r.req_type = REQ_UNUSED;
    send_request(r);
    check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    send_key(check_str);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= CALM_AFTER) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = key_item(8'($urandom), $urandom_range(0, 3) == 0);
      end else if (pick < 78) begin
        case ($urandom_range(0, 5))
          0: begin
            lo = 0;
            hi = SLOTS - 1;
          end
          1: begin
            lo = $urandom_range(1, SLOTS - 1);
            hi = $urandom_range(0, lo - 1);
          end
          default: begin
            lo = $urandom_range(0, SLOTS - 1);
            hi = lo + $urandom_range(0, 4000);
            if (hi > SLOTS - 1) hi = SLOTS - 1;
          end
        endcase
        r = range_item($urandom_range(0, RANGES - 1), $urandom_range(0, 5) != 0, lo, hi,
                       $urandom_range(0, SHARDS - 1));
      end else if (pick < 95) begin
        r = status_item($urandom_range(0, SHARDS - 1), 1'($urandom), 1'($urandom));
      end else begin
        r = filler();
        r.req_type = REQ_UNUSED;
      end
      send_request(r);
      if (r.req_type != REQ_UNUSED) done++;
    end
    req_valid <= 1'b0;

    while (sb.routes_due.size() != 0) @(posedge clk);
    repeat (RANGES + 40) @(posedge clk);
    if (sb.errors == 0 && sb.routes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
